// ----- design/lbrx_pkg.sv -----
`timescale 1ns / 1ps

package lbrx_pkg;

    // character codes that steer the receive path and line reads
    localparam logic [7:0] CHR_NUL = 8'd0;
    localparam logic [7:0] CHR_LF  = 8'd10;
    localparam logic [7:0] CHR_CR  = 8'd13;

    // a line read gives at most this many characters before its end beat
    localparam int         CHARS_W        = 6;
    localparam logic [CHARS_W-1:0] LINE_CHARS_MAX = 6'd63;

    // command codes; the spare code is served by the default arm
    typedef enum logic [1:0] {
        CMD_RX   = 2'd0,
        CMD_POP  = 2'd1,
        CMD_LINE = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_FLUSH     = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_LINE_CHAR = 3'd5,
        ST_LINE_END  = 3'd6,
        ST_NO_LINE   = 3'd7
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_LINE_FETCH,
        S_LINE_WAIT,
        S_LINE_END
    } state_t;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
        logic [7:0] line_count;
    } res_t;

endpackage

// ----- design/lbrx_if.sv -----
`timescale 1ns / 1ps

// command channel
interface lbrx_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// result channel
interface lbrx_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
    logic [7:0] line_count;

    modport source (output valid, output out_byte, output status, output last,
                    output line_count, input ready);
    modport sink   (input valid, input out_byte, input status, input last,
                    input line_count, output ready);
endinterface

// ----- design/lbrx_ring.sv -----
`timescale 1ns / 1ps

module lbrx_ring #(
    parameter int RING_DEPTH = 64,
    localparam int ADDR_W = $clog2(RING_DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/lbrx_ctrl.sv -----
`timescale 1ns / 1ps

module lbrx_ctrl #(
    parameter int RING_DEPTH = 64,
    localparam int ADDR_W = $clog2(RING_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    lbrx_cmd_if.sink          cmd,
    input  logic              can_emit,
    output logic              res_valid,
    output lbrx_pkg::res_t    res,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output logic [7:0]        mem_wr_data,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_rd_addr,
    input  logic [7:0]        mem_rd_data
);

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(RING_DEPTH - 1);

    lbrx_pkg::state_t              state_reg, state_next;
    logic [ADDR_W-1:0]             head_reg, head_next;
    logic [ADDR_W-1:0]             tail_reg, tail_next;
    logic [7:0]                    lines_reg, lines_next;
    logic [lbrx_pkg::CHARS_W-1:0]  chars_reg, chars_next;

    logic [ADDR_W-1:0] head_adv;
    logic [ADDR_W-1:0] tail_adv;
    logic              empty;
    logic              rd_is_end;

    // wrapping index advance
    assign head_adv  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_adv  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign empty     = (head_reg == tail_reg);
    assign rd_is_end = (mem_rd_data == lbrx_pkg::CHR_CR)
                    || (mem_rd_data == lbrx_pkg::CHR_NUL);

    // state and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbrx_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            lines_reg <= '0;
            chars_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            lines_reg <= lines_next;
            chars_reg <= chars_next;
        end
    end

    // sequencer: commands are taken one at a time, so a ring write and a
    // ring read never touch the same entry in overlapping cycles
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        lines_next   = lines_reg;
        chars_next   = chars_reg;
        cmd.ready    = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = head_adv;
        mem_wr_data  = cmd.data_byte;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = tail_adv;

        case (state_reg)
            lbrx_pkg::S_IDLE:
            begin
                cmd.ready = can_emit;
                if (cmd.valid && can_emit)
                begin
                    case (cmd.command)
                        lbrx_pkg::CMD_RX:
                        begin
                            res_valid = 1'b1;
                            res.last  = 1'b1;
                            if (head_adv == tail_reg)
                            begin
                                // full ring: flush, byte lost
                                head_next  = tail_reg;
                                res.status = lbrx_pkg::ST_FLUSH;
                            end
                            else if ((cmd.data_byte == lbrx_pkg::CHR_NUL)
                                  || (cmd.data_byte == lbrx_pkg::CHR_LF))
                            begin
                                res.status = lbrx_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                mem_wr_en  = 1'b1;
                                head_next  = head_adv;
                                res.status = lbrx_pkg::ST_STORED;
                                if (cmd.data_byte == lbrx_pkg::CHR_CR)
                                begin
                                    lines_next = lines_reg + 8'd1;
                                end
                            end
                        end
                        lbrx_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                res_valid  = 1'b1;
                                res.last   = 1'b1;
                                res.status = lbrx_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                tail_next  = tail_adv;
                                state_next = lbrx_pkg::S_POP_WAIT;
                            end
                        end
                        lbrx_pkg::CMD_LINE:
                        begin
                            if (lines_reg == 8'd0)
                            begin
                                res_valid  = 1'b1;
                                res.last   = 1'b1;
                                res.status = lbrx_pkg::ST_NO_LINE;
                            end
                            else
                            begin
                                chars_next = '0;
                                state_next = lbrx_pkg::S_LINE_FETCH;
                            end
                        end
                        default:
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = lbrx_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end

            // popped byte arrives from the ring
            lbrx_pkg::S_POP_WAIT:
            begin
                if (can_emit)
                begin
                    res_valid    = 1'b1;
                    res.out_byte = mem_rd_data;
                    res.status   = lbrx_pkg::ST_POPPED;
                    res.last     = 1'b1;
                    state_next   = lbrx_pkg::S_IDLE;
                end
            end

            // first fetch of a line
            lbrx_pkg::S_LINE_FETCH:
            begin
                if (empty || (chars_reg == lbrx_pkg::LINE_CHARS_MAX))
                begin
                    state_next = lbrx_pkg::S_LINE_END;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    tail_next  = tail_adv;
                    state_next = lbrx_pkg::S_LINE_WAIT;
                end
            end

            // end on CR or NUL, else emit the byte, prefetch the next
            lbrx_pkg::S_LINE_WAIT:
            begin
                if (rd_is_end)
                begin
                    state_next = lbrx_pkg::S_LINE_END;
                end
                else if (can_emit)
                begin
                    res_valid    = 1'b1;
                    res.out_byte = mem_rd_data;
                    res.status   = lbrx_pkg::ST_LINE_CHAR;
                    chars_next   = chars_reg + 1'b1;
                    if ((chars_reg != lbrx_pkg::LINE_CHARS_MAX - 1'b1) && !empty)
                    begin
                        mem_rd_en = 1'b1;
                        tail_next = tail_adv;
                    end
                    else
                    begin
                        state_next = lbrx_pkg::S_LINE_END;
                    end
                end
            end

            // end marker, one line fewer
            lbrx_pkg::S_LINE_END:
            begin
                if (can_emit)
                begin
                    lines_next = lines_reg - 8'd1;
                    res_valid  = 1'b1;
                    res.status = lbrx_pkg::ST_LINE_END;
                    res.last   = 1'b1;
                    state_next = lbrx_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lbrx_pkg::S_IDLE;
            end
        endcase

        res.line_count = lines_next;
    end

endmodule

// ----- design/line_buffered_rx_fifo.sv -----
`timescale 1ns / 1ps

// channel  dir  fields                                 beat
// -------  ---  -------------------------------------  -----------------------
// cmd      in   command, data_byte                     valid && ready
// rsp      out  out_byte, status, last, line_count     valid && ready
//
// receive, empty pop, no-line and spare commands: answered when taken, result
// beat registered the cycle after. a pop that finds a byte reads the ring and
// returns it from S_POP_WAIT. a line read runs S_LINE_FETCH, then S_LINE_WAIT
// per character and S_LINE_END; it ends at CR, an empty ring or the length cap.
// reset clears the pointers and line count at once; ring contents are kept.
// the result register lets a new command in while it is being drained.
module line_buffered_rx_fifo #(
    parameter int RING_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    lbrx_cmd_if.sink  cmd,
    lbrx_rsp_if.source rsp
);

    localparam int ADDR_W = $clog2(RING_DEPTH);

    logic              can_emit;
    logic              res_valid;
    lbrx_pkg::res_t    res;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    logic              out_valid_reg;
    lbrx_pkg::res_t    out_reg;

    // sequencer with pointers and line count
    lbrx_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .can_emit    (can_emit),
        .res_valid   (res_valid),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // byte ring
    lbrx_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // result register
    assign can_emit = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_byte   = out_reg.out_byte;
    assign rsp.status     = out_reg.status;
    assign rsp.last       = out_reg.last;
    assign rsp.line_count = out_reg.line_count;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || rsp.ready))
        else $error("result overwrote a waiting beat");

    // ring reads and writes come from different commands
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !mem_rd_en)
        else $error("ring read and write in the same cycle");

    // a ring read keeps the command side closed while its data is in flight
    a_busy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |=> !cmd.ready)
        else $error("command taken while ring read pending");

endmodule
